// File: hw/rtl/cehc_pkg.sv
// Shared types and constants for the call edge hash counter.
// Used by every module of the block; depends on nothing.
package cehc_pkg;

    localparam int CFG_W      = 13;
    localparam int ID_W       = 32;
    localparam int CNT_W      = 32;
    localparam int IDX_W      = 12;
    localparam int OCC_W      = 13;
    localparam int SLOT_MAX_W = 16;
    localparam int ROT_AMOUNT = 16;
    localparam int HASH_STEPS = 32;
    localparam int STEP_W     = 5;

    localparam logic [CFG_W-1:0] SIZE_RESET = 13'd4093;
    localparam logic [CNT_W-1:0] SAT32      = 32'hFFFF_FFFF;
    localparam logic [OCC_W-1:0] OCC_MAX    = 13'h1FFF;

    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_NEW      = 2'd0,
        ST_EXISTING = 2'd1,
        ST_FULL     = 2'd2,
        ST_READ     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_CHECK
    } back_state_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [ID_W-1:0]       parent;
        logic [ID_W-1:0]       child;
        logic [SLOT_MAX_W-1:0] home;
        logic [IDX_W-1:0]      slot_index;
    } work_item_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  parent;
        logic [ID_W-1:0]  child;
        logic [CNT_W-1:0] count;
    } mem_word_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

// File: hw/rtl/cehc_front.sv
// Front end: accepts items and reduces the edge hash modulo the table size.
// Depends on cehc_pkg; feeds cehc_fifo.
module cehc_front #(
    parameter int SZW = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SZW-1:0]       sz,
    input  cehc_pkg::back_status_t back_st,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [31:0]          parent_id,
    input  logic [31:0]          child_id,
    input  logic [11:0]          slot_index,
    input  logic                 fifo_full,
    output logic                 push,
    output cehc_pkg::work_item_t push_item
);

    cehc_pkg::front_state_t state_reg, state_next;
    cehc_pkg::work_item_t item_reg, item_next;
    logic [31:0] div_reg, div_next;
    logic [SZW-1:0] rem_reg, rem_next;
    logic [cehc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [SZW:0] shifted;
    logic [SZW:0] reduced;
    logic accept;

    assign accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cehc_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cehc_pkg::cmd_t'(command) == cehc_pkg::CMD_READ)
                                 ? cehc_pkg::F_PUSH : cehc_pkg::F_HASH;
                end
            end
            cehc_pkg::F_HASH:
            begin
                if (step_reg == cehc_pkg::STEP_W'(cehc_pkg::HASH_STEPS - 1))
                begin
                    state_next = cehc_pkg::F_PUSH;
                end
            end
            cehc_pkg::F_PUSH:
            begin
                if (!fifo_full)
                begin
                    state_next = cehc_pkg::F_IDLE;
                end
            end
            default: state_next = cehc_pkg::F_IDLE;
        endcase
    end

    // restoring remainder: one dividend bit per cycle
    always_comb
    begin
        shifted = {rem_reg, div_reg[31]};
        reduced = (shifted >= {1'b0, sz}) ? shifted - {1'b0, sz} : shifted;
    end

    // outputs and datapath
    always_comb
    begin
        in_stall  = (state_reg != cehc_pkg::F_IDLE) || back_st.clearing;
        push      = (state_reg == cehc_pkg::F_PUSH) && !fifo_full;
        push_item = item_reg;
        item_next = item_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        case (state_reg)
            cehc_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    item_next.cmd        = cehc_pkg::cmd_t'(command);
                    item_next.parent     = parent_id;
                    item_next.child      = child_id;
                    item_next.slot_index = slot_index;
                    item_next.home       = '0;
                    div_next  = {parent_id[cehc_pkg::ROT_AMOUNT-1:0],
                                 parent_id[31:cehc_pkg::ROT_AMOUNT]} ^ child_id;
                    rem_next  = '0;
                    step_next = '0;
                end
            end
            cehc_pkg::F_HASH:
            begin
                rem_next  = SZW'(reduced);
                div_next  = {div_reg[30:0], 1'b0};
                step_next = step_reg + 1'b1;
                item_next.home = cehc_pkg::SLOT_MAX_W'(reduced);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cehc_pkg::F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

endmodule

// File: hw/rtl/cehc_fifo.sv
// Two-entry queue of work items between the front end and the probe engine.
// Depends on cehc_pkg.
module cehc_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cehc_pkg::work_item_t push_item,
    input  logic                 pop,
    output cehc_pkg::work_item_t head,
    output logic                 full,
    output logic                 empty
);

    cehc_pkg::work_item_t mem_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full        = (cnt_reg == 2'd2);
        empty       = (cnt_reg == 2'd0);
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/cehc_back.sv
// Probe engine: slot memory, linear probing, counters and the result register.
// Depends on cehc_pkg; drains cehc_fifo.
module cehc_back #(
    parameter int TABLE_DEPTH = 4096,
    parameter int SZW         = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SZW-1:0]       sz,
    input  cehc_pkg::work_item_t head,
    input  logic                 fifo_empty,
    output logic                 pop,
    output cehc_pkg::back_status_t back_st,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [11:0]          slot,
    output logic                 collided,
    output logic                 entry_valid,
    output logic [31:0]          entry_parent,
    output logic [31:0]          entry_child,
    output logic [31:0]          entry_count,
    output logic [12:0]          occupied_entries,
    output logic [31:0]          total_insertions,
    output logic [31:0]          total_collisions,
    output logic                 over_half
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int FCW = $clog2(TABLE_DEPTH + 1);
    localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

    cehc_pkg::mem_word_t mem [TABLE_DEPTH];
    cehc_pkg::mem_word_t rd_reg;

    cehc_pkg::back_state_t state_reg, state_next;
    cehc_pkg::work_item_t item_reg, item_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [AW-1:0]  cur_reg, cur_next;
    logic [SZW-1:0] n_reg, n_next;
    logic           coll_reg, coll_next;
    logic           oob_reg, oob_next;
    logic [FCW-1:0] fill_reg, fill_next;
    logic [31:0]    ins_reg, ins_next;
    logic [31:0]    colt_reg, colt_next;

    logic                out_valid_reg, out_valid_next;
    cehc_pkg::status_t   status_reg, status_next;
    logic [11:0]         slot_reg, slot_next;
    logic                collided_reg, collided_next;
    cehc_pkg::mem_word_t ent_reg, ent_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    cehc_pkg::mem_word_t mem_wdata;
    logic out_free, hit, last_probe;
    logic [SZW-1:0] cur_wide;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        hit        = rd_reg.valid && (rd_reg.parent == item_reg.parent)
                     && (rd_reg.child == item_reg.child);
        last_probe = (n_reg + 1'b1) == sz;
        cur_wide   = SZW'(cur_reg) + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cehc_pkg::B_CLEAR:
            begin
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = cehc_pkg::B_IDLE;
                end
            end
            cehc_pkg::B_IDLE:
            begin
                if (!fifo_empty && out_free)
                begin
                    state_next = cehc_pkg::B_PROBE;
                end
            end
            cehc_pkg::B_PROBE: state_next = cehc_pkg::B_CHECK;
            cehc_pkg::B_CHECK:
            begin
                if (item_reg.cmd == cehc_pkg::CMD_RECORD && rd_reg.valid && !hit
                    && !last_probe)
                begin
                    state_next = cehc_pkg::B_PROBE;
                end
                else
                begin
                    state_next = cehc_pkg::B_IDLE;
                end
            end
            default: state_next = cehc_pkg::B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop            = 1'b0;
        back_st.clearing = (state_reg == cehc_pkg::B_CLEAR);
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = rd_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        coll_next      = coll_reg;
        oob_next       = oob_reg;
        item_next      = item_reg;
        fill_next      = fill_reg;
        ins_next       = ins_reg;
        colt_next      = colt_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        collided_next  = collided_reg;
        ent_next       = ent_reg;
        out_valid_next = (out_valid_reg && out_stall);

        case (state_reg)
            cehc_pkg::B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            cehc_pkg::B_IDLE:
            begin
                if (!fifo_empty && out_free)
                begin
                    pop       = 1'b1;
                    item_next = head;
                    n_next    = '0;
                    coll_next = 1'b0;
                    if (head.cmd == cehc_pkg::CMD_READ)
                    begin
                        cur_next = AW'(head.slot_index);
                        oob_next = {5'd0, head.slot_index} >= DEPTH17;
                    end
                    else
                    begin
                        cur_next = AW'(head.home);
                        oob_next = 1'b0;
                    end
                end
            end
            cehc_pkg::B_CHECK:
            begin
                if (item_reg.cmd == cehc_pkg::CMD_READ)
                begin
                    out_valid_next = 1'b1;
                    status_next    = cehc_pkg::ST_READ;
                    slot_next      = item_reg.slot_index;
                    collided_next  = 1'b0;
                    ent_next       = (rd_reg.valid && !oob_reg) ? rd_reg : '0;
                end
                else if (hit || !rd_reg.valid || last_probe)
                begin
                    out_valid_next = 1'b1;
                    ins_next       = cehc_pkg::sat_inc(ins_reg);
                    slot_next      = 12'(cur_reg);
                    if (hit)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata.count = cehc_pkg::sat_inc(rd_reg.count);
                        status_next     = cehc_pkg::ST_EXISTING;
                        collided_next   = coll_reg;
                        ent_next        = mem_wdata;
                    end
                    else if (!rd_reg.valid)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata.valid  = 1'b1;
                        mem_wdata.parent = item_reg.parent;
                        mem_wdata.child  = item_reg.child;
                        mem_wdata.count  = 32'd1;
                        fill_next        = fill_reg + 1'b1;
                        status_next      = cehc_pkg::ST_NEW;
                        collided_next    = coll_reg;
                        ent_next         = mem_wdata;
                    end
                    else
                    begin
                        // every slot in use holds some other edge
                        status_next   = cehc_pkg::ST_FULL;
                        slot_next     = 12'(item_reg.home);
                        collided_next = sz > SZW'(1);
                        ent_next      = '0;
                    end
                    if (collided_next)
                    begin
                        colt_next = cehc_pkg::sat_inc(colt_reg);
                    end
                end
                else
                begin
                    // advance to the next slot, wrapping at the size in use
                    cur_next  = (cur_wide == sz) ? '0 : AW'(cur_wide);
                    n_next    = n_reg + 1'b1;
                    coll_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cehc_pkg::B_CLEAR;
            clr_reg       <= '0;
            fill_reg      <= '0;
            ins_reg       <= '0;
            colt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fill_reg      <= fill_next;
            ins_reg       <= ins_next;
            colt_reg      <= colt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cur_reg      <= cur_next;
        n_reg        <= n_next;
        coll_reg     <= coll_next;
        oob_reg      <= oob_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        collided_reg <= collided_next;
        ent_reg      <= ent_next;
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[cur_reg];
    end

    always_comb
    begin
        out_valid        = out_valid_reg;
        status           = status_reg;
        slot             = slot_reg;
        collided         = collided_reg;
        entry_valid      = ent_reg.valid;
        entry_parent     = ent_reg.parent;
        entry_child      = ent_reg.child;
        entry_count      = ent_reg.count;
        occupied_entries = (32'(fill_reg) > 32'(cehc_pkg::OCC_MAX))
                           ? cehc_pkg::OCC_MAX : 13'(fill_reg);
        total_insertions = ins_reg;
        total_collisions = colt_reg;
        over_half        = 32'(fill_reg) > 32'(sz >> 1);
    end

endmodule

// File: hw/rtl/call_edge_hash_counter_unit.sv
// Top level of the call edge hash counter: table size register and the
// front end, queue and probe engine. Depends on cehc_pkg, cehc_front,
// cehc_fifo and cehc_back.
//
// Input (in_valid / in_stall): command 0 records the edge parent_id -> child_id,
//   command 1 reads slot slot_index. An item is taken at a clock edge with
//   in_valid high and in_stall low.
// Output (out_valid / out_stall): one result per item, in order.
// Config: cfg_wr_en / cfg_wr_data write table_size; write only while idle.
// Flow: a record is hashed by the serial remainder, one remainder bit per cycle,
//   enters the queue and leaves it, then each probed slot takes a memory read
//   and a compare/update; the result is registered at the compare/update of
//   the last probed slot. A read skips the hash, passes the queue, then takes
//   one memory read and one compare before its result is registered.
// Overlap: the front end takes a new item only after its last one has entered
//   the queue, and the probe engine works on one item at a time.
//   Probing of one item overlaps the hash of the next through the queue.
// Reset: the probe engine clears the slot memory, one slot per cycle, and
//   in_stall stays high until it is done. Counters clear and table_size
//   returns to 4093.
// Stall: hold a stalled result in its register; the queue takes two items,
//   then the front end holds its item and keeps in_stall high.
module call_edge_hash_counter_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] parent_id,
    input  logic [31:0] child_id,
    input  logic [11:0] slot_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [11:0] slot,
    output logic        collided,
    output logic        entry_valid,
    output logic [31:0] entry_parent,
    output logic [31:0] entry_child,
    output logic [31:0] entry_count,
    output logic [12:0] occupied_entries,
    output logic [31:0] total_insertions,
    output logic [31:0] total_collisions,
    output logic        over_half
);

    // size in use must hold TABLE_DEPTH itself
    localparam int SZW = ($clog2(TABLE_DEPTH) + 1 > cehc_pkg::CFG_W)
                         ? $clog2(TABLE_DEPTH) + 1 : cehc_pkg::CFG_W;

    logic [cehc_pkg::CFG_W-1:0] table_size_reg;
    logic [SZW-1:0]             sz;

    cehc_pkg::work_item_t   push_item, head;
    cehc_pkg::back_status_t back_st;
    logic push, pop, fifo_full, fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= cehc_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            table_size_reg <= cfg_wr_data;
        end
    end

    // clamp the size: zero counts as one, anything past the memory as its depth
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            sz = SZW'(1);
        end
        else if (SZW'(table_size_reg) > SZW'(TABLE_DEPTH))
        begin
            sz = SZW'(TABLE_DEPTH);
        end
        else
        begin
            sz = SZW'(table_size_reg);
        end
    end

    cehc_front #(
        .SZW (SZW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sz         (sz),
        .back_st    (back_st),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .parent_id  (parent_id),
        .child_id   (child_id),
        .slot_index (slot_index),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_item  (push_item)
    );

    cehc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    cehc_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SZW         (SZW)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .sz               (sz),
        .head             (head),
        .fifo_empty       (fifo_empty),
        .pop              (pop),
        .back_st          (back_st),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .slot             (slot),
        .collided         (collided),
        .entry_valid      (entry_valid),
        .entry_parent     (entry_parent),
        .entry_child      (entry_child),
        .entry_count      (entry_count),
        .occupied_entries (occupied_entries),
        .total_insertions (total_insertions),
        .total_collisions (total_collisions),
        .over_half        (over_half)
    );

endmodule

// File: hw/rtl/cehc_checker.sv
// Port-level checks for call_edge_hash_counter_unit, bound to the top level.
// Depends on cehc_pkg.
module cehc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        collided,
    input logic        entry_valid,
    input logic [31:0] entry_parent,
    input logic [31:0] entry_child,
    input logic [31:0] entry_count
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result dropped or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cehc_pkg::ST_READ |-> !collided)
        else $error("read result flagged a collision");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |->
            entry_parent == '0 && entry_child == '0 && entry_count == '0)
        else $error("empty entry carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cehc_pkg::ST_FULL |-> !entry_valid)
        else $error("full result shows an entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cehc_pkg::ST_NEW || status == cehc_pkg::ST_EXISTING)
            |-> entry_valid && entry_count != '0)
        else $error("stored edge without a count");

endmodule

bind call_edge_hash_counter_unit cehc_checker u_cehc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .collided     (collided),
    .entry_valid  (entry_valid),
    .entry_parent (entry_parent),
    .entry_child  (entry_child),
    .entry_count  (entry_count)
);
